### rtl/core/bur_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bur_pkg
// Shared types and constants of the budgeted undo/redo history.
// ----------------------------------------------------------------------------
package bur_pkg;

    localparam int DEF_HISTORY_DEPTH = 64;

    localparam int ME_W   = 6;   // max_entries, entry_count and cursor_pos width
    localparam int COST_W = 32;  // byte cost, byte budget and byte total width
    localparam int VER_W  = 64;  // version count width
    localparam int CMD_W  = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [ME_W-1:0]   RST_MAX_ENTRIES = 6'd63;
    localparam logic [COST_W-1:0] RST_MAX_BYTES   = 32'd1048576;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENTRIES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_BYTES   = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_EXECUTE = 3'd0,
        CMD_UNDO    = 3'd1,
        CMD_REDO    = 3'd2,
        CMD_CLEAR   = 3'd3,
        CMD_TRIM    = 3'd4
    } t_cmd;

    typedef struct packed {
        logic [ME_W-1:0]   max_entries;
        logic [COST_W-1:0] max_bytes;
    } t_cfg;

    typedef struct packed {
        logic              accepted;
        logic [ME_W-1:0]   entry_count;
        logic [ME_W-1:0]   cursor_pos;
        logic [COST_W-1:0] bytes_used;
        logic [VER_W-1:0]  change_count;
        logic              can_undo;
        logic              can_redo;
    } t_result;

endpackage
`default_nettype wire

### rtl/core/bur_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bur_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bur_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/core/bur_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bur_ctrl
// Command sequencer: holds the cursor, count and totals, and walks the cost
// ring to drop the redo tail and evict the oldest entries.
// ----------------------------------------------------------------------------
module bur_ctrl #(
    parameter int HISTORY_DEPTH = bur_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire bur_pkg::t_cfg                    i_cfg,
    input  wire logic                             i_in_valid,
    output logic                                  o_in_ready,
    input  wire logic [bur_pkg::CMD_W-1:0]        i_command,
    input  wire logic [bur_pkg::COST_W-1:0]       i_entry_cost,
    input  wire logic                             i_action_ok,
    output logic                                  o_res_valid,
    input  wire logic                             i_res_ready,
    output bur_pkg::t_result                      o_res,
    output logic                                  o_ram_we,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      o_ram_waddr,
    output logic [bur_pkg::COST_W-1:0]            o_ram_wdata,
    output logic [$clog2(HISTORY_DEPTH)-1:0]      o_ram_raddr,
    input  wire logic [bur_pkg::COST_W-1:0]       i_ram_rdata
);

    localparam int IW = $clog2(HISTORY_DEPTH);
    localparam int CW = $clog2(HISTORY_DEPTH + 1);
    localparam int LW = (CW > bur_pkg::ME_W) ? CW : bur_pkg::ME_W;
    localparam int TW = bur_pkg::COST_W + 1;

    localparam logic [IW:0]   DEPTH_X   = (IW + 1)'(HISTORY_DEPTH);
    localparam logic [LW-1:0] DEPTH_L   = LW'(HISTORY_DEPTH);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HISTORY_DEPTH);
    localparam logic [IW-1:0] LAST_SLOT = IW'(HISTORY_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAIL,
        S_APPEND,
        S_EVICT,
        S_BUD_CHK,
        S_DONE
    } t_state;

    t_state                      r_state, n_state;
    logic [IW-1:0]               r_oldest, n_oldest;
    logic [CW-1:0]               r_count, n_count;
    logic [CW-1:0]               r_cursor, n_cursor;
    logic [TW-1:0]               r_total, n_total;
    logic [bur_pkg::VER_W-1:0]   r_version, n_version;
    logic                        r_acc, n_acc;
    logic                        r_pend, n_pend;
    logic                        r_bud, n_bud;
    logic [bur_pkg::COST_W-1:0]  r_cost, n_cost;

    logic [IW:0]     tail_sum, app_sum;
    logic [IW-1:0]   tail_slot, app_slot, oldest_nxt;
    logic [LW-1:0]   me_l, lim;
    logic            over_budget, exec_ok;

    // Ring slot of an offset from the oldest entry; the sum stays below twice the depth.
    assign tail_sum   = (IW + 1)'(r_oldest) + (IW + 1)'(CW'(r_count - CW'(1)));
    assign app_sum    = (IW + 1)'(r_oldest) + (IW + 1)'(r_count);
    assign tail_slot  = (tail_sum >= DEPTH_X) ? IW'(tail_sum - DEPTH_X) : IW'(tail_sum);
    assign app_slot   = (app_sum >= DEPTH_X) ? IW'(app_sum - DEPTH_X) : IW'(app_sum);
    assign oldest_nxt = (r_oldest == LAST_SLOT) ? '0 : IW'(r_oldest + IW'(1));

    assign me_l = LW'(i_cfg.max_entries);
    assign lim  = (me_l < DEPTH_L) ? me_l : DEPTH_L;
    assign over_budget = (r_count != '0) &&
                         ((LW'(r_count) > lim) || (r_total > TW'(i_cfg.max_bytes)));

    assign exec_ok = (i_cfg.max_entries != '0) && (i_cfg.max_bytes != '0) &&
                     (i_entry_cost != '0) && (i_entry_cost <= i_cfg.max_bytes) &&
                     i_action_ok;

    always_comb begin
        n_state   = r_state;
        n_oldest  = r_oldest;
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_total   = r_total;
        n_version = r_version;
        n_acc     = r_acc;
        n_pend    = r_pend;
        n_bud     = r_bud;
        n_cost    = r_cost;
        o_ram_we    = 1'b0;
        o_ram_waddr = app_slot;
        o_ram_wdata = r_cost;
        o_ram_raddr = r_oldest;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cost = i_entry_cost;
                    n_acc  = 1'b0;
                    n_state = S_DONE;
                    unique case (i_command)
                        bur_pkg::CMD_EXECUTE: begin
                            if (exec_ok) begin
                                n_pend  = 1'b0;
                                n_state = S_TAIL;
                            end
                        end
                        bur_pkg::CMD_UNDO: begin
                            if ((r_cursor != '0) && i_action_ok) begin
                                n_cursor  = CW'(r_cursor - CW'(1));
                                n_version = r_version + 1'b1;
                                n_acc     = 1'b1;
                            end
                        end
                        bur_pkg::CMD_REDO: begin
                            if ((r_cursor < r_count) && i_action_ok) begin
                                n_cursor  = CW'(r_cursor + CW'(1));
                                n_version = r_version + 1'b1;
                                n_acc     = 1'b1;
                            end
                        end
                        bur_pkg::CMD_CLEAR: begin
                            n_oldest  = '0;
                            n_count   = '0;
                            n_cursor  = '0;
                            n_total   = '0;
                            n_version = r_version + 1'b1;
                            n_acc     = 1'b1;
                        end
                        bur_pkg::CMD_TRIM: begin
                            n_acc   = 1'b1;
                            n_state = S_BUD_CHK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_TAIL: begin
                // Reads of the redo tail run one ahead of the subtraction.
                if (r_pend) begin
                    n_total = r_total - TW'(i_ram_rdata);
                end
                if (r_count > r_cursor) begin
                    o_ram_raddr = tail_slot;
                    n_count = CW'(r_count - CW'(1));
                    n_pend  = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_APPEND;
                end
            end
            S_APPEND: begin
                if (r_count == DEPTH_C) begin
                    o_ram_raddr = r_oldest;
                    n_bud   = 1'b0;
                    n_state = S_EVICT;
                end else begin
                    o_ram_we  = 1'b1;
                    n_count   = CW'(r_count + CW'(1));
                    n_cursor  = CW'(r_count + CW'(1));
                    n_total   = r_total + TW'(r_cost);
                    n_version = r_version + 1'b1;
                    n_acc     = 1'b1;
                    n_state   = S_BUD_CHK;
                end
            end
            S_EVICT: begin
                n_total  = r_total - TW'(i_ram_rdata);
                n_oldest = oldest_nxt;
                n_count  = CW'(r_count - CW'(1));
                if (r_cursor != '0) begin
                    n_cursor = CW'(r_cursor - CW'(1));
                end
                n_state = r_bud ? S_BUD_CHK : S_APPEND;
            end
            S_BUD_CHK: begin
                if (over_budget) begin
                    o_ram_raddr = r_oldest;
                    n_bud   = 1'b1;
                    n_state = S_EVICT;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_oldest  <= '0;
            r_count   <= '0;
            r_cursor  <= '0;
            r_total   <= '0;
            r_version <= '0;
            r_acc     <= 1'b0;
            r_pend    <= 1'b0;
            r_bud     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_oldest  <= n_oldest;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_total   <= n_total;
            r_version <= n_version;
            r_acc     <= n_acc;
            r_pend    <= n_pend;
            r_bud     <= n_bud;
        end
        r_cost <= n_cost;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);

    always_comb begin
        o_res.accepted     = r_acc;
        o_res.entry_count  = bur_pkg::ME_W'(r_count);
        o_res.cursor_pos   = bur_pkg::ME_W'(r_cursor);
        o_res.bytes_used   = r_total[bur_pkg::COST_W-1:0];
        o_res.change_count = r_version;
        o_res.can_undo     = (r_cursor != '0);
        o_res.can_redo     = (r_cursor < r_count);
    end

    a_cursor_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cursor <= r_count)
        else $error("undo cursor above entry count");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_C)
        else $error("entry count above history depth");

    a_write_only_append: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> (r_state == S_APPEND) && (r_count < DEPTH_C))
        else $error("ring written outside an append or into a full ring");

    a_total_fits_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_total[TW-1])
        else $error("byte total left above 32 bits");

    a_done_after_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BUD_CHK) && !over_budget |=> (r_state == S_DONE))
        else $error("budget check did not finish the request");

endmodule
`default_nettype wire

### rtl/core/budgeted_undo_redo_history.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// budgeted_undo_redo_history
// Undo/redo history of entry byte costs held in a ring RAM, with entry-count
// and byte budgets.
// ----------------------------------------------------------------------------
// Usage: a request on the input channel carries a command (execute, undo, redo,
// clear, trim), an entry cost and the external action status. Each request
// gives exactly one result with the new count, cursor, byte total, version
// and undo/redo flags. The block works on one request at a time.
// Undo, redo, clear, rejected and unknown commands go straight to the result;
// trim runs the budget check and its evictions; execute drops the redo tail,
// appends (evicting the oldest entry first when the ring is full) and then
// runs the budget check. The cost ring RAM has a registered read, so tail
// drops are pipelined one read ahead, while each budget eviction waits for
// its read.
// A new request is taken the cycle after a result is handed to the output
// register, even while that result still waits to be taken. A stalled
// receiver holds the next result inside the block and the input stays closed.
// The configuration port is always ready; writes take effect at once and do
// not trim. Reset empties the history and loads the register defaults; it
// needs no clearing pass.
// ----------------------------------------------------------------------------
module budgeted_undo_redo_history #(
    parameter int HISTORY_DEPTH = bur_pkg::DEF_HISTORY_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [bur_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bur_pkg::COST_W-1:0]        i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [bur_pkg::CMD_W-1:0]         i_command,
    input  wire logic [bur_pkg::COST_W-1:0]        i_entry_cost,
    input  wire logic                              i_action_ok,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic                                   o_accepted,
    output logic [bur_pkg::ME_W-1:0]               o_entry_count,
    output logic [bur_pkg::ME_W-1:0]               o_cursor_pos,
    output logic [bur_pkg::COST_W-1:0]             o_bytes_used,
    output logic [bur_pkg::VER_W-1:0]              o_change_count,
    output logic                                   o_can_undo,
    output logic                                   o_can_redo
);

    localparam int IW = $clog2(HISTORY_DEPTH);

    bur_pkg::t_cfg     r_cfg;
    bur_pkg::t_result  r_out;
    logic              r_out_valid;

    bur_pkg::t_result  res;
    logic              res_valid, res_ready;
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [bur_pkg::COST_W-1:0] ram_wdata, ram_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_entries <= bur_pkg::RST_MAX_ENTRIES;
            r_cfg.max_bytes   <= bur_pkg::RST_MAX_BYTES;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bur_pkg::CFG_MAX_ENTRIES: r_cfg.max_entries <= i_cfg_data[bur_pkg::ME_W-1:0];
                bur_pkg::CFG_MAX_BYTES:   r_cfg.max_bytes   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    bur_ram #(
        .WIDTH (bur_pkg::COST_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    bur_ctrl #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_entry_cost (i_entry_cost),
        .i_action_ok  (i_action_ok),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_ram_we     (ram_we),
        .o_ram_waddr  (ram_waddr),
        .o_ram_wdata  (ram_wdata),
        .o_ram_raddr  (ram_raddr),
        .i_ram_rdata  (ram_rdata)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_accepted     = r_out.accepted;
    assign o_entry_count  = r_out.entry_count;
    assign o_cursor_pos   = r_out.cursor_pos;
    assign o_bytes_used   = r_out.bytes_used;
    assign o_change_count = r_out.change_count;
    assign o_can_undo     = r_out.can_undo;
    assign o_can_redo     = r_out.can_redo;

endmodule
`default_nettype wire

### verif/budgeted_undo_redo_history_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// budgeted_undo_redo_history_checker
// Watches the configuration, request and result channels of the undo/redo
// history. It keeps its own copy of the cost ring, cursor, byte total and
// version count, predicts the snapshot that each request must produce, and
// compares every returned snapshot field by field, in order.
// ----------------------------------------------------------------------------
module budgeted_undo_redo_history_checker
    import bur_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COST_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 o_in_ready,
    input  logic [CMD_W-1:0]     i_command,
    input  logic [COST_W-1:0]    i_entry_cost,
    input  logic                 i_action_ok,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic                 o_accepted,
    input  logic [ME_W-1:0]      o_entry_count,
    input  logic [ME_W-1:0]      o_cursor_pos,
    input  logic [COST_W-1:0]    o_bytes_used,
    input  logic [VER_W-1:0]     o_change_count,
    input  logic                 o_can_undo,
    input  logic                 o_can_redo,
    output int                   fail_count,
    output int                   pending_count
);

    localparam int DEPTH = DEF_HISTORY_DEPTH;

    logic [COST_W-1:0] cost_ring [DEPTH];
    logic [ME_W-1:0]   oldest;
    logic [ME_W:0]     held;
    logic [ME_W:0]     cursor;
    logic [COST_W-1:0] byte_total;
    logic [VER_W-1:0]  version;
    t_cfg              limits;
    t_result           expected_snapshots [$];
    int                errors = 0;

    // The ring depth is a power of two, so the slot index simply wraps.
    function automatic logic [ME_W-1:0] ring_slot(logic [ME_W:0] offset);
        return oldest + offset[ME_W-1:0];
    endfunction

    function automatic void evict_oldest(inout logic [63:0] total);
        total  -= cost_ring[oldest];
        oldest += 1'b1;
        held   -= 1'b1;
        if (cursor > 0)
            cursor -= 1'b1;
    endfunction

    function automatic void enforce_budget(inout logic [63:0] total);
        while (held > 0 && (held > {1'b0, limits.max_entries} ||
                            total > {32'd0, limits.max_bytes}))
            evict_oldest(total);
    endfunction

    function automatic t_result apply_history_command(logic [CMD_W-1:0] cmd,
                                                      logic [COST_W-1:0] cost,
                                                      logic ok);
        logic [63:0] total;
        t_result     snap;
        total = {32'd0, byte_total};
        snap  = '0;
        case (cmd)
            CMD_EXECUTE: begin
                if (limits.max_entries != 0 && limits.max_bytes != 0 && cost != 0 &&
                    cost <= limits.max_bytes && ok) begin
                    // Everything above the cursor is the redo tail and goes first.
                    while (held > cursor) begin
                        held  -= 1'b1;
                        total -= cost_ring[ring_slot(held)];
                    end
                    if (held >= DEPTH)
                        evict_oldest(total);
                    cost_ring[ring_slot(held)] = cost;
                    held  += 1'b1;
                    total += cost;
                    cursor = held;
                    enforce_budget(total);
                    version += 1'b1;
                    snap.accepted = 1'b1;
                end
            end
            CMD_UNDO: begin
                if (cursor > 0 && ok) begin
                    cursor  -= 1'b1;
                    version += 1'b1;
                    snap.accepted = 1'b1;
                end
            end
            CMD_REDO: begin
                if (cursor < held && ok) begin
                    cursor  += 1'b1;
                    version += 1'b1;
                    snap.accepted = 1'b1;
                end
            end
            CMD_CLEAR: begin
                oldest  = '0;
                held    = '0;
                cursor  = '0;
                total   = '0;
                version += 1'b1;
                snap.accepted = 1'b1;
            end
            CMD_TRIM: begin
                enforce_budget(total);
                snap.accepted = 1'b1;
            end
            default: ;
        endcase
        byte_total        = total[COST_W-1:0];
        snap.entry_count  = held[ME_W-1:0];
        snap.cursor_pos   = cursor[ME_W-1:0];
        snap.bytes_used   = byte_total;
        snap.change_count = version;
        snap.can_undo     = cursor > 0;
        snap.can_redo     = cursor < held;
        return snap;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            oldest     = '0;
            held       = '0;
            cursor     = '0;
            byte_total = '0;
            version    = '0;
            limits.max_entries = RST_MAX_ENTRIES;
            limits.max_bytes   = RST_MAX_BYTES;
            expected_snapshots.delete();
        end else begin
            // Results are checked before new requests are predicted, so a
            // result can never be matched against a request of the same edge.
            if (o_out_valid && i_out_ready) begin
                if (expected_snapshots.size() == 0) begin
                    $display("%0t ns: result returned with no request outstanding", $time);
                    errors++;
                end else begin
                    want = expected_snapshots.pop_front();
                    check_field("accepted", want.accepted, o_accepted);
                    check_field("entry_count", want.entry_count, o_entry_count);
                    check_field("cursor_pos", want.cursor_pos, o_cursor_pos);
                    check_field("bytes_used", want.bytes_used, o_bytes_used);
                    check_field("change_count", want.change_count, o_change_count);
                    check_field("can_undo", want.can_undo, o_can_undo);
                    check_field("can_redo", want.can_redo, o_can_redo);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_ENTRIES: limits.max_entries = i_cfg_data[ME_W-1:0];
                    CFG_MAX_BYTES:   limits.max_bytes   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready)
                expected_snapshots.insert(expected_snapshots.size(),
                    apply_history_command(i_command, i_entry_cost, i_action_ok));
        end
        fail_count    <= errors;
        pending_count <= expected_snapshots.size();
    end

endmodule

### verif/budgeted_undo_redo_history_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// budgeted_undo_redo_history_tb
// Drives the undo/redo history with a directed opening and then phases of
// random commands under a range of entry and byte limits, with random gaps
// on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module budgeted_undo_redo_history_tb;
    import bur_pkg::*;

    localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 300;
    localparam int PHASES        = 10;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [COST_W-1:0] cost;
        logic              ok;
    } t_history_request;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_valid  = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [COST_W-1:0]    i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic [CMD_W-1:0]     i_command    = '0;
    logic [COST_W-1:0]    i_entry_cost = '0;
    logic                 i_action_ok  = 1'b0;
    logic                 i_out_ready  = 1'b0;
    logic                 o_cfg_ready;
    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_accepted;
    logic [ME_W-1:0]      o_entry_count;
    logic [ME_W-1:0]      o_cursor_pos;
    logic [COST_W-1:0]    o_bytes_used;
    logic [VER_W-1:0]     o_change_count;
    logic                 o_can_undo;
    logic                 o_can_redo;

    int                fail_count;
    int                pending_count;
    int                quiet_cycles = 0;
    bit                jitter_on    = 1'b1;
    logic [COST_W-1:0] byte_budget  = RST_MAX_BYTES;

    always #1 i_clk = ~i_clk;

    budgeted_undo_redo_history u_top (.*);

    budgeted_undo_redo_history_checker u_checker (.*);

    always @(posedge i_clk)
        i_out_ready <= !jitter_on || ($urandom_range(99) >= 34);

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Both registers are written back to back; valid stays high between them.
    task automatic set_limits(logic [ME_W-1:0] entries, logic [COST_W-1:0] bytes);
        logic [COST_W-1:0] word;
        word = $urandom();
        word[ME_W-1:0] = entries;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_MAX_ENTRIES;
        i_cfg_data  <= word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= CFG_MAX_BYTES;
        i_cfg_data  <= bytes;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        byte_budget = bytes;
    endtask

    task automatic issue(logic [CMD_W-1:0] cmd, logic [COST_W-1:0] cost, logic ok);
        while (jitter_on && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_entry_cost <= cost;
        i_action_ok  <= ok;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
    endtask

    function automatic logic [COST_W-1:0] pick_cost();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 45)
            return $urandom_range(1, 16);
        if (r < 75)
            return $urandom_range(1, byte_budget / 8 + 1);
        if (r < 85)
            return $urandom();
        if (r < 95)
            return $urandom_range(1) ? byte_budget : byte_budget + 1;
        return '0;
    endfunction

    function automatic t_history_request random_request();
        t_history_request req;
        int unsigned      r;
        r = $urandom_range(99);
        req.ok = $urandom_range(99) < 90;
        if (r < 50)
            req.cmd = CMD_EXECUTE;
        else if (r < 68)
            req.cmd = CMD_UNDO;
        else if (r < 82)
            req.cmd = CMD_REDO;
        else if (r < 84)
            req.cmd = CMD_CLEAR;
        else if (r < 94)
            req.cmd = CMD_TRIM;
        else
            req.cmd = $urandom_range(CMD_SPARE_LO, CMD_SPARE_HI);
        req.cost = (req.cmd == CMD_EXECUTE) ? pick_cost() : COST_W'($urandom());
        return req;
    endfunction

    initial begin : stimulus
        int                me_plan [PHASES] = '{63, 1, 0, 63, 2, 0, 63, 0, 5, 63};
        logic [COST_W-1:0] mb_plan [PHASES] = '{32'hFFFF_FFFF, 32'd1048576, 32'd500,
                                                32'd0, 32'd1, 32'd0, 32'd1048576,
                                                32'd0, 32'd100, 32'd4000};
        int                count_plan [PHASES] = '{150, 130, 60, 60, 120, 150, 250,
                                                   150, 120, 110};
        t_history_request  req;
        int                burst_left;
        bit                burst_fill;
        logic [ME_W-1:0]   entries;
        logic [COST_W-1:0] bytes;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        set_limits(6'd4, 32'd1000);
        issue(CMD_UNDO, '0, 1'b1);          // nothing to undo yet
        issue(CMD_REDO, '0, 1'b1);          // nothing to redo yet
        issue(CMD_EXECUTE, '0, 1'b1);       // zero cost is refused
        issue(CMD_EXECUTE, 32'd1001, 1'b1); // cost above the byte budget
        issue(CMD_EXECUTE, 32'd300, 1'b0);  // the outside action failed
        issue(CMD_EXECUTE, 32'd300, 1'b1);
        issue(CMD_EXECUTE, 32'd400, 1'b1);
        issue(CMD_EXECUTE, 32'd300, 1'b1);  // exactly at the byte budget
        issue(CMD_EXECUTE, 32'd200, 1'b1);  // over budget, the oldest goes
        issue(CMD_UNDO, '0, 1'b0);
        issue(CMD_UNDO, '0, 1'b1);
        issue(CMD_UNDO, '0, 1'b1);
        issue(CMD_REDO, '0, 1'b1);
        issue(CMD_REDO, '0, 1'b0);
        issue(CMD_EXECUTE, 32'd1000, 1'b1); // redo tail dropped, then budget evictions
        repeat (5) issue(CMD_EXECUTE, 32'd1, 1'b1);
        issue(CMD_SPARE_LO, 32'hFFFF_FFFF, 1'b1);
        issue(CMD_SPARE_HI, '0, 1'b0);
        issue(CMD_TRIM, '0, 1'b1);
        issue(CMD_CLEAR, '0, 1'b1);
        drain();

        for (int phase = 0; phase < PHASES; phase++) begin
            entries = me_plan[phase];
            bytes   = mb_plan[phase];
            if (phase == 5) begin
                entries = $urandom_range(1, 63);
                bytes   = $urandom_range(1, 65535);
            end
            if (phase == 7) begin
                entries = $urandom_range(1, 63);
                bytes   = $urandom();
            end
            set_limits(entries, bytes);
            jitter_on = (phase != 6);
            if (phase == 0) begin
                // Two maximal costs push the running sum past 32 bits.
                issue(CMD_EXECUTE, 32'hFFFF_FFFF, 1'b1);
                issue(CMD_EXECUTE, 32'hFFFF_FFFE, 1'b1);
            end
            // The history left by the last phase may be over the new limits.
            issue(CMD_TRIM, $urandom(), $urandom_range(1));
            burst_left = (phase == 6 || phase == 9) ? 70 : 0;
            burst_fill = 1'b1;
            repeat (count_plan[phase]) begin
                if (burst_left == 0 && $urandom_range(99) < 3) begin
                    burst_left = $urandom_range(8, 70);
                    burst_fill = $urandom_range(3) != 0;
                end
                if (burst_left > 0) begin
                    burst_left--;
                    if (burst_fill)
                        issue(CMD_EXECUTE, $urandom_range(1, 4), 1'b1);
                    else
                        issue(CMD_UNDO, $urandom(), 1'b1);
                end else begin
                    req = random_request();
                    issue(req.cmd, req.cost, req.ok);
                end
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
